>>> design/tps_pkg.sv
`timescale 1ns / 1ps

package tps_pkg;

  // CORDIC datapath widths: x/y in 2^-16 m, z in 2^-24 rad
  localparam int X_W       = 27;
  localparam int Z_W       = 28;
  localparam int ANG_W     = 16;
  localparam int DIST_W    = 21;
  localparam int TF_W      = 17;
  localparam int TURN_W    = 20;
  localparam int SPEED_W   = 19;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int ATAN_N    = 24;

  // Stream payload widths
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 40;

  // Fixed-point constants
  localparam logic signed [Z_W-1:0] HALF_PI_Q24 = Z_W'(26353589);
  localparam logic [15:0]           INV_GAIN_Q16 = 16'd39797;
  localparam logic [12:0]           HALF_PI_Q12 = 13'd6434;
  // floor(2^32 / 6434): reciprocal for the turn-factor quotient
  localparam logic [19:0]           TF_RECIP = 20'd667542;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADING_GAIN       = 3'd0,
    REG_DISTANCE_GAIN      = 3'd1,
    REG_SPEED_LIMIT        = 3'd2,
    REG_TURN_RATE_LIMIT    = 3'd3,
    REG_YAW_COMPENSATION   = 3'd4,
    REG_SPEED_COMPENSATION = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] heading_gain;
    logic [CFG_W-1:0] distance_gain;
    logic [CFG_W-1:0] speed_limit;
    logic [CFG_W-1:0] turn_rate_limit;
    logic [CFG_W-1:0] yaw_compensation;
    logic [CFG_W-1:0] speed_compensation;
  } cfg_t;

  // One classified target: zero marks an item whose command is forced to zero
  typedef struct packed {
    logic                  zero;
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
  } item_t;

  // atan(2^-i) in 2^-24 rad
  function automatic logic signed [Z_W-1:0] atan_q24(input int unsigned i);
    logic signed [Z_W-1:0] a;
    unique case (i)
      0:  a = Z_W'(13176795);
      1:  a = Z_W'(7778716);
      2:  a = Z_W'(4110060);
      3:  a = Z_W'(2086331);
      4:  a = Z_W'(1047214);
      5:  a = Z_W'(524117);
      6:  a = Z_W'(262123);
      7:  a = Z_W'(131069);
      8:  a = Z_W'(65536);
      9:  a = Z_W'(32768);
      10: a = Z_W'(16384);
      11: a = Z_W'(8192);
      12: a = Z_W'(4096);
      13: a = Z_W'(2048);
      14: a = Z_W'(1024);
      15: a = Z_W'(512);
      16: a = Z_W'(256);
      17: a = Z_W'(128);
      18: a = Z_W'(64);
      19: a = Z_W'(32);
      20: a = Z_W'(16);
      21: a = Z_W'(8);
      22: a = Z_W'(4);
      23: a = Z_W'(2);
      default: a = '0;
    endcase
    return a;
  endfunction

  // One vectoring micro-rotation: drive y toward zero
  function automatic item_t cordic_iter(input item_t s, input int unsigned i);
    item_t                 r;
    logic signed [X_W-1:0] dx;
    logic signed [X_W-1:0] dy;
    r  = s;
    dx = s.y >>> i;
    dy = s.x >>> i;
    if (!s.y[X_W-1]) begin
      r.x = s.x + dx;
      r.y = s.y - dy;
      r.z = s.z + atan_q24(i);
    end else begin
      r.x = s.x - dx;
      r.y = s.y + dy;
      r.z = s.z - atan_q24(i);
    end
    return r;
  endfunction

endpackage

>>> design/tps_front.sv
`timescale 1ns / 1ps

module tps_front (
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [tps_pkg::S_DATA_W-1:0]     s_tdata,   // [15:0] target_x, [31:16] target_y
  input  logic                             s_tuser,   // [0] target_valid
  input  logic                             q_full,
  output logic                             push,
  output tps_pkg::item_t                   item
);

  logic signed [15:0]                tx;
  logic signed [15:0]                ty;
  logic signed [tps_pkg::X_W-1:0]    x0;
  logic signed [tps_pkg::X_W-1:0]    y0;

  assign tx = s_tdata[15:0];
  assign ty = s_tdata[31:16];
  assign x0 = tps_pkg::X_W'($signed({tx, 8'h00}));
  assign y0 = tps_pkg::X_W'($signed({ty, 8'h00}));

  // Take a transfer whenever the queue has room
  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  // Classify and pre-rotate into the right half plane
  always_comb begin
    item.zero = !s_tuser || (tx == 16'sd0 && ty == 16'sd0);
    if (tx[15]) begin
      if (!ty[15]) begin
        item.x = y0;
        item.y = -x0;
        item.z = tps_pkg::HALF_PI_Q24;
      end else begin
        item.x = -y0;
        item.y = x0;
        item.z = -tps_pkg::HALF_PI_Q24;
      end
    end else begin
      item.x = x0;
      item.y = y0;
      item.z = '0;
    end
  end

endmodule

>>> design/tps_queue.sv
`timescale 1ns / 1ps

module tps_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tps_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output tps_pkg::item_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tps_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> design/tps_cordic.sv
`timescale 1ns / 1ps

module tps_cordic #(
  parameter int STEPS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  tps_pkg::item_t in_item,
  output logic           out_valid,
  output tps_pkg::item_t out_item
);

  logic [STEPS:1] vld;
  tps_pkg::item_t st [1:STEPS];

  assign out_valid = vld[STEPS];
  assign out_item  = st[STEPS];

  // Shift stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STEPS-1:1], in_valid};
    end
  end

  // One micro-rotation per stage
  always_ff @(posedge clk) begin
    if (en) begin
      st[1] <= tps_pkg::cordic_iter(in_item, 0);
      for (int unsigned i = 1; i < STEPS; i++) begin
        st[i+1] <= tps_pkg::cordic_iter(st[i], i);
      end
    end
  end

endmodule

>>> design/tps_back.sv
`timescale 1ns / 1ps

module tps_back (
  input  logic                         clk,
  input  logic                         rst,
  input  tps_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  input  tps_pkg::item_t               in_item,
  output logic                         en,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [tps_pkg::M_DATA_W-1:0] m_tdata   // [19:0] turn_rate_cmd, [38:20] forward_speed_cmd
);

  localparam int NST = 10;

  logic [NST:1] vld;

  // Stage 1
  logic signed [tps_pkg::ANG_W-1:0]  ang1;
  logic signed [43:0]                dp1;
  logic                              zero1;
  // Stage 2
  logic signed [32:0]                w2;
  logic [12:0]                       aabs2;
  logic                              big2;
  logic [32:0]                       p2;
  logic [tps_pkg::DIST_W-1:0]        dist2;
  logic                              zero2;
  // Stage 3
  logic signed [17:0]                wc3;
  logic [15:0]                       qe3;
  logic [12:0]                       aabs3;
  logic                              big3;
  logic [tps_pkg::DIST_W-1:0]        dist3;
  logic                              zero3;
  // Stage 4
  logic signed [34:0]                wy4;
  logic [15:0]                       qe4;
  logic [28:0]                       qm4;
  logic [28:0]                       n4;
  logic                              big4;
  logic [tps_pkg::DIST_W-1:0]        dist4;
  logic                              zero4;
  // Stage 5
  logic [tps_pkg::TURN_W-1:0]        wo5;
  logic [tps_pkg::TF_W-1:0]          tf5;
  logic [tps_pkg::DIST_W-1:0]        dist5;
  logic                              zero5;
  // Stages 6 to 9
  logic [tps_pkg::TURN_W-1:0]        wo6, wo7, wo8, wo9;
  logic [37:0]                       a6;
  logic [34:0]                       pl7;
  logic [34:0]                       ph7;
  logic [15:0]                       vc8;
  logic [31:0]                       vs9;
  logic                              zero6, zero7, zero8, zero9;
  // Output register
  logic [tps_pkg::TURN_W-1:0]        turn_out;
  logic [tps_pkg::SPEED_W-1:0]       speed_out;

  // Combinational terms between stages
  logic signed [43:0]                dsum;
  logic [15:0]                       abs_n;
  logic signed [32:0]                wsum;
  logic signed [20:0]                wr;
  logic signed [20:0]                lim;
  logic signed [20:0]                wcl;
  logic signed [34:0]                ysum;
  logic [28:0]                       rem;
  logic [15:0]                       q;
  logic [53:0]                       psum;
  logic [25:0]                       vr;
  logic [32:0]                       vsum;
  logic [24:0]                       vo;

  // Stall the whole pipe while a result waits at the output
  assign en       = !m_tvalid || m_tready;
  assign m_tvalid = vld[NST];
  assign m_tdata  = {1'b0, speed_out, turn_out};

  always_comb begin
    dsum  = dp1 + 44'sd524288;
    abs_n = ang1[tps_pkg::ANG_W-1] ? 16'(-ang1) : 16'(ang1);

    // Round heading term and clamp to the turn limit
    wsum = w2 + 33'sd2048;
    wr   = $signed(wsum[32:12]);
    lim  = $signed({5'b0, cfg.turn_rate_limit});
    if (wr > lim) begin
      wcl = lim;
    end else if (wr < -lim) begin
      wcl = -lim;
    end else begin
      wcl = wr;
    end

    // Fix up the reciprocal quotient by one
    ysum = wy4 + 35'sd128;
    rem  = n4 - qm4;
    q    = (rem >= 29'(tps_pkg::HALF_PI_Q12)) ? qe4 + 16'd1 : qe4;

    // Recombine partial products and round
    psum = {ph7, 19'b0} + 54'(pl7) + 54'd134217728;
    vr   = psum[53:28];

    vsum = 33'(vs9) + 33'd128;
    vo   = vsum[32:8];
  end

  // Shift stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-1:1], in_valid};
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: round angle, scale magnitude by inverse CORDIC gain
      ang1  <= $signed(in_item.z[tps_pkg::Z_W-1:12] + 16'(in_item.z[11]));
      dp1   <= in_item.x * $signed({1'b0, tps_pkg::INV_GAIN_Q16});
      zero1 <= in_item.zero;

      // Stage 2: distance, heading product, reciprocal product
      dist2 <= dsum[40:20];
      w2    <= $signed({1'b0, cfg.heading_gain}) * ang1;
      aabs2 <= abs_n[12:0];
      big2  <= (abs_n >= 16'(tps_pkg::HALF_PI_Q12));
      p2    <= 33'(abs_n[12:0]) * 33'(tps_pkg::TF_RECIP);
      zero2 <= zero1;

      // Stage 3: clamp turn, estimate quotient
      wc3   <= 18'(wcl);
      qe3   <= p2[31:16];
      aabs3 <= aabs2;
      big3  <= big2;
      dist3 <= dist2;
      zero3 <= zero2;

      // Stage 4: yaw scaling, quotient check product
      wy4   <= wc3 * $signed({1'b0, cfg.yaw_compensation});
      qe4   <= qe3;
      qm4   <= 29'(qe3) * 29'(tps_pkg::HALF_PI_Q12);
      n4    <= {aabs3, 16'h0000};
      big4  <= big3;
      dist4 <= dist3;
      zero4 <= zero3;

      // Stage 5: saturate turn, form turn factor
      if (ysum[34:27] == {8{ysum[27]}}) begin
        wo5 <= ysum[27:8];
      end else begin
        wo5 <= ysum[34] ? 20'h80000 : 20'h7FFFF;
      end
      tf5   <= big4 ? '0 : 17'h10000 - 17'(q);
      dist5 <= dist4;
      zero5 <= zero4;

      // Stage 6: distance times turn factor
      a6    <= 38'(dist5) * 38'(tf5);
      wo6   <= wo5;
      zero6 <= zero5;

      // Stage 7: gain in two partial products
      pl7   <= 35'(cfg.distance_gain) * 35'(a6[18:0]);
      ph7   <= 35'(cfg.distance_gain) * 35'(a6[37:19]);
      wo7   <= wo6;
      zero7 <= zero6;

      // Stage 8: clamp to speed limit
      vc8   <= (vr > 26'(cfg.speed_limit)) ? cfg.speed_limit : vr[15:0];
      wo8   <= wo7;
      zero8 <= zero7;

      // Stage 9: speed compensation
      vs9   <= 32'(vc8) * 32'(cfg.speed_compensation);
      wo9   <= wo8;
      zero9 <= zero8;

      // Output register: saturate speed, drop commands for stop items
      turn_out  <= zero9 ? '0 : wo9;
      speed_out <= zero9 ? '0 : ((|vo[24:19]) ? 19'h7FFFF : vo[18:0]);
    end
  end

endmodule

>>> design/target_pursuit_steering.sv
`timescale 1ns / 1ps
// Throughput: one target per cycle while the output is not stalled; CORDIC_STEPS micro-rotation
// stages (the first loads straight from the queue) and ten multiply/round/clamp stages set the latency.
// The whole pipe stalls while a result waits; the QUEUE_DEPTH-entry queue takes input while not full.
// Reset (rst, synchronous, active high) empties queue and pipe and loads register defaults.

module target_pursuit_steering #(
  parameter int CORDIC_STEPS = 16,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tps_pkg::S_DATA_W-1:0]      s_tdata,   // [15:0] target_x, [31:16] target_y
  input  logic                              s_tuser,   // [0] target_valid
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tps_pkg::M_DATA_W-1:0]      m_tdata,   // [19:0] turn_rate_cmd, [38:20] forward_speed_cmd
  input  logic                              cfg_write,
  input  logic [tps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tps_pkg::CFG_W-1:0]         cfg_data
);

  tps_pkg::cfg_t  cfg;
  tps_pkg::item_t front_item;
  tps_pkg::item_t head_item;
  tps_pkg::item_t cordic_item;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_not_empty;
  logic           en;
  logic           cordic_valid;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heading_gain       <= 16'd8192;
      cfg.distance_gain      <= 16'd2048;
      cfg.speed_limit        <= 16'd1229;
      cfg.turn_rate_limit    <= 16'd6144;
      cfg.yaw_compensation   <= 16'd1969;
      cfg.speed_compensation <= 16'd427;
    end else if (cfg_write) begin
      unique case (tps_pkg::reg_index_t'(cfg_index))
        tps_pkg::REG_HEADING_GAIN:       cfg.heading_gain       <= cfg_data;
        tps_pkg::REG_DISTANCE_GAIN:      cfg.distance_gain      <= cfg_data;
        tps_pkg::REG_SPEED_LIMIT:        cfg.speed_limit        <= cfg_data;
        tps_pkg::REG_TURN_RATE_LIMIT:    cfg.turn_rate_limit    <= cfg_data;
        tps_pkg::REG_YAW_COMPENSATION:   cfg.yaw_compensation   <= cfg_data;
        tps_pkg::REG_SPEED_COMPENSATION: cfg.speed_compensation <= cfg_data;
        default:                         cfg                    <= cfg;
      endcase
    end
  end

  tps_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .item     (front_item)
  );

  tps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  // Feed the pipe whenever it advances and the queue holds an item
  assign pop = en && q_not_empty;

  tps_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pop),
    .in_item   (head_item),
    .out_valid (cordic_valid),
    .out_item  (cordic_item)
  );

  tps_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (cordic_valid),
    .in_item  (cordic_item),
    .en       (en),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> design/tps_checker.sv
`timescale 1ns / 1ps

module tps_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [tps_pkg::M_DATA_W-1:0] m_tdata
);

  logic [15:0] pending;

  // Count items taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 16'(s_tvalid && s_tready) - 16'(m_tvalid && m_tready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_out_has_item: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 16'd0)
    else $error("result without a pending item");

  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> pending != 16'd0)
    else $error("input blocked with nothing in flight");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind target_pursuit_steering tps_checker u_tps_checker (.*);

>>> tb/tb_target_pursuit_steering.sv
`timescale 1ns / 1ps

module tb_target_pursuit_steering;
  import tps_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int LATENCY      = CORDIC_STEPS + 11;
  localparam int QUIET_LIMIT  = 4000;
  localparam int NUM_DIRECTED = 21;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 135;

  // Indexes past the register file; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam longint QTR_TURN_Q24    = 26353589;
  localparam longint QTR_TURN_Q12    = 6434;
  localparam longint CORDIC_INV_GAIN = 39797;
  localparam longint TURN_MAX        = 524287;
  localparam longint TURN_MIN        = -524288;
  localparam longint SPEED_MAX       = 524287;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [TURN_W-1:0]  turn;
  } steer_cmd_t;

  typedef struct packed {
    logic               valid;
    logic [15:0]        x;
    logic [15:0]        y;
    logic               typed;
    logic [SPEED_W-1:0] speed;
    logic [TURN_W-1:0]  turn;
  } target_row_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata   = '0;
  logic                 s_tuser   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HEADING_GAIN;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // Shadow copy of the register file
  longint hdg_gain   = 8192;
  longint dist_gain  = 2048;
  longint speed_lim  = 1229;
  longint turn_lim   = 6144;
  longint yaw_comp   = 1969;
  longint speed_comp = 427;

  longint atan_rad_q24 [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  steer_cmd_t pending_cmds [$];
  int         mismatch_count = 0;
  int         quiet_cycles   = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;

  // Directed targets; stop commands and the origin carry their command inline
  target_row_t directed_rows [NUM_DIRECTED] = '{
    '{1'b0, 16'h0000, 16'h0000, 1'b1, 19'd0, 20'd0},
    '{1'b0, 16'h7FFF, 16'h8000, 1'b1, 19'd0, 20'd0},
    '{1'b0, 16'h8000, 16'h7FFF, 1'b1, 19'd0, 20'd0},
    '{1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 19'd0, 20'd0},
    '{1'b1, 16'h0000, 16'h0000, 1'b1, 19'd0, 20'd0},
    '{1'b1, 16'h0100, 16'h0000, 1'b0, 19'd0, 20'd0},
    '{1'b1, 16'hFF00, 16'h0000, 1'b0, 19'd0, 20'd0},
    '{1'b1, 16'h8000, 16'h0000, 1'b0, 19'd0, 20'd0},
    '{1'b1, 16'h0000, 16'h0100, 1'b0, 19'd0, 20'd0},
    '{1'b1, 16'h0000, 16'hFF00, 1'b0, 19'd0, 20'd0},
    '{1'b1, 16'h7FFF, 16'h7FFF, 1'b0, 19'd0, 20'd0},
    '{1'b1, 16'h8000, 16'h8000, 1'b0, 19'd0, 20'd0},
    '{1'b1, 16'h7FFF, 16'h8000, 1'b0, 19'd0, 20'd0},
    '{1'b1, 16'h8000, 16'h7FFF, 1'b0, 19'd0, 20'd0},
    '{1'b1, 16'h7FFF, 16'h0000, 1'b0, 19'd0, 20'd0},
    '{1'b1, 16'h0000, 16'h7FFF, 1'b0, 19'd0, 20'd0},
    '{1'b1, 16'h0000, 16'h8000, 1'b0, 19'd0, 20'd0},
    '{1'b1, 16'h0001, 16'h0000, 1'b0, 19'd0, 20'd0},
    '{1'b1, 16'hFFFF, 16'h0000, 1'b0, 19'd0, 20'd0},
    '{1'b1, 16'h0000, 16'h0001, 1'b0, 19'd0, 20'd0},
    '{1'b1, 16'h0200, 16'hFF00, 1'b0, 19'd0, 20'd0}
  };

  target_pursuit_steering #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [15:0] target_x, [31:16] target_y
    .s_tuser   (s_tuser),    // [0] target_valid
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [19:0] turn_rate_cmd, [38:20] forward_speed_cmd
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Work out the velocity command for one target under the shadow registers
  function automatic steer_cmd_t predict_steer(logic valid, logic signed [15:0] tx,
                                               logic signed [15:0] ty);
    longint     x, y, z, t, dx, dy, ang, range_q12, aabs, tf, w, v;
    steer_cmd_t cmd;
    cmd = '0;
    if (!valid) return cmd;
    ang       = 0;
    range_q12 = 0;
    if (tx != 0 || ty != 0) begin
      x = longint'(tx) * 256;
      y = longint'(ty) * 256;
      z = 0;
      // rotate the rear half-plane forward by a quarter turn
      if (x < 0) begin
        if (y >= 0) begin
          t = y; y = -x; x = t; z = QTR_TURN_Q24;
        end else begin
          t = -y; y = x; x = t; z = -QTR_TURN_Q24;
        end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += atan_rad_q24[i];
        end else begin
          x -= dx; y += dy; z -= atan_rad_q24[i];
        end
      end
      ang       = (z + 2048) >>> 12;
      range_q12 = (x * CORDIC_INV_GAIN + 524288) >>> 20;
    end

    // angular command: gain, clamp to the turn limit, compensate, saturate
    w = (hdg_gain * ang + 2048) >>> 12;
    if (w > turn_lim) w = turn_lim;
    else if (w < -turn_lim) w = -turn_lim;
    w = (w * yaw_comp + 128) >>> 8;
    if (w > TURN_MAX) w = TURN_MAX;
    else if (w < TURN_MIN) w = TURN_MIN;

    // linear command: slow down as heading error grows, stop past a quarter turn
    aabs = (ang < 0) ? -ang : ang;
    tf = 65536 - (aabs * 65536) / QTR_TURN_Q12;
    if (tf < 0) tf = 0;
    v = (dist_gain * range_q12 * tf + 134217728) >>> 28;
    if (v > speed_lim) v = speed_lim;
    else if (v < 0) v = 0;
    v = (v * speed_comp + 128) >>> 8;
    if (v > SPEED_MAX) v = SPEED_MAX;
    else if (v < 0) v = 0;

    cmd.turn  = TURN_W'(w);
    cmd.speed = SPEED_W'(v);
    return cmd;
  endfunction

  function automatic logic [15:0] corner_coord();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // Offer one target, hold it until the transfer, then queue its command
  task automatic send_target(logic valid, logic [15:0] tx, logic [15:0] ty,
                             logic typed, steer_cmd_t typed_cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= valid;
    s_tdata  <= {ty, tx};
    do @(posedge clk); while (!s_tready);
    pending_cmds.push_back(typed ? typed_cmd : predict_steer(valid, tx, ty));
  endtask

  // Drop valid and wait for every queued command to come back
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_HEADING_GAIN:       hdg_gain   = value;
      REG_DISTANCE_GAIN:      dist_gain  = value;
      REG_SPEED_LIMIT:        speed_lim  = value;
      REG_TURN_RATE_LIMIT:    turn_lim   = value;
      REG_YAW_COMPENSATION:   yaw_comp   = value;
      REG_SPEED_COMPENSATION: speed_comp = value;
      default: ;
    endcase
  endtask

  // Phase 1 loads all ones, phase 2 all zeros, phase 3 moderate values,
  // later phases a mix of extremes and random values
  task automatic load_setting(int phase);
    logic [CFG_W-1:0] value;
    for (int r = int'(REG_HEADING_GAIN); r <= int'(REG_SPEED_COMPENSATION); r++) begin
      if (phase == 1) value = '1;
      else if (phase == 2) value = '0;
      else if (phase == 3) value = CFG_W'($urandom_range(8191));
      else begin
        case ($urandom_range(3))
          0:       value = '0;
          1:       value = '1;
          default: value = CFG_W'($urandom_range(65535));
        endcase
      end
      write_reg(CFG_IDX_W'(r), value);
    end
    write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_W'($urandom));
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Stall the command side at random
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each command transfer with the oldest queued command
  always @(posedge clk) begin : check_cmds
    steer_cmd_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected command, expected none, actual turn %0d speed %0d",
                 $time, $signed(m_tdata[TURN_W-1:0]), m_tdata[TURN_W+SPEED_W-1:TURN_W]);
        mismatch_count++;
      end else begin
        want = pending_cmds.pop_front();
        if (m_tdata[TURN_W-1:0] !== want.turn) begin
          $display("%0t: turn_rate_cmd expected %0d actual %0d", $time,
                   $signed(want.turn), $signed(m_tdata[TURN_W-1:0]));
          mismatch_count++;
        end
        if (m_tdata[TURN_W+SPEED_W-1:TURN_W] !== want.speed) begin
          $display("%0t: forward_speed_cmd expected %0d actual %0d", $time,
                   want.speed, m_tdata[TURN_W+SPEED_W-1:TURN_W]);
          mismatch_count++;
        end
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] tx;
    logic [15:0] ty;
    logic        tv;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed targets under reset settings, no idling
    foreach (directed_rows[k]) begin
      send_target(directed_rows[k].valid, directed_rows[k].x, directed_rows[k].y,
                  directed_rows[k].typed, {directed_rows[k].speed, directed_rows[k].turn});
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p > 0) load_setting(p);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      repeat (PHASE_ITEMS) begin
        tv = ($urandom_range(9) != 0);
        case ($urandom_range(9))
          0, 1, 2, 3, 4: {ty, tx} = $urandom;
          5, 6, 7: begin
            tx = 16'($urandom_range(4095) - 2048);
            ty = 16'($urandom_range(4095) - 2048);
          end
          8: begin
            // target on an axis
            tx = 16'($urandom);
            ty = '0;
            if ($urandom_range(1)) {tx, ty} = {ty, tx};
          end
          default: begin
            tx = corner_coord();
            ty = corner_coord();
          end
        endcase
        send_target(tv, tx, ty, 1'b0, '0);
      end
    end

    drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> target_pursuit_steering.f
design/tps_pkg.sv
design/tps_front.sv
design/tps_queue.sv
design/tps_cordic.sv
design/tps_back.sv
design/target_pursuit_steering.sv
design/tps_checker.sv
tb/tb_target_pursuit_steering.sv
